@@ hdl/qsm3_pkg.sv @@
// Package: shared constants and types for the median-of-three quicksort core.
`default_nettype none
package qsm3_pkg;
    localparam int MaxItems = 64;
    localparam int IdxW     = $clog2(MaxItems);
    localparam int CntW     = $clog2(MaxItems + 1);

    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_SORT  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // one (low, high) pending subrange
    typedef struct packed {
        logic [IdxW-1:0] lo;
        logic [IdxW-1:0] hi;
    } range_t;

    // signed compare a < b
    function automatic logic lt32(input logic [31:0] a, input logic [31:0] b);
        lt32 = $signed(a) < $signed(b);
    endfunction
endpackage
`default_nettype wire

@@ hdl/qsm3_ram.sv @@
// Generic single-port synchronous RAM with registered read.
`default_nettype none
module qsm3_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] addr,
    input  wire logic [Width-1:0]         wdata,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

@@ hdl/quicksort_median_of_three_core.sv @@
// Top level: value store, quicksort sequencer and result stream.
//
// Add, clear and unused requests are accepted, then give one result that is held
// until the receiver takes it. A sort runs quicksort in place on a single-port
// value RAM and a single-port range-stack RAM. Each partitioned range goes
// through the median of three, pivot placement, the up and down scans with
// their exchanges, the final swap, the pushes of the subranges and a pop. The
// sorted values then stream out one at a time, each held until the receiver
// takes it. No other request is taken until the last result of a request has
// been delivered.
`default_nettype none
module quicksort_median_of_three_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // action[1:0], item_value[33:2], zero pad
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // out_value[31:0], out_valid[32], accepted[33],
                                        // stored_count[40:34], zero pad
    output logic             m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int IW = qsm3_pkg::IdxW;
    localparam int CW = qsm3_pkg::CntW;

    localparam logic [4:0] ST_IDLE  = 5'd0,  ST_OUT   = 5'd1,  ST_M0    = 5'd2,
                           ST_M1    = 5'd3,  ST_M2    = 5'd4,  ST_M3    = 5'd5,
                           ST_MSW   = 5'd6,  ST_POP   = 5'd7,  ST_POPW  = 5'd8,
                           ST_PSW0  = 5'd9,  ST_UPR   = 5'd11,
                           ST_UPC   = 5'd12, ST_DNC   = 5'd14,
                           ST_SWW   = 5'd15, ST_SWW2  = 5'd16, ST_FIN   = 5'd17,
                           ST_FIN2  = 5'd18, ST_PUSH1 = 5'd19, ST_PUSH2 = 5'd20,
                           ST_EMITR = 5'd21, ST_EMIT  = 5'd22, ST_M2W   = 5'd23,
                           ST_M3W   = 5'd24;

    logic [4:0]    state_reg, state_next;
    logic [6:0]    cap_reg;
    logic [CW-1:0] fill_reg, fill_next;
    logic [IW-1:0] lo_reg, lo_next, hi_reg, hi_next, mid_reg, mid_next;
    logic [IW-1:0] up_reg, up_next, dn_reg, dn_next, ei_reg, ei_next;
    logic [CW-1:0] sp_reg, sp_next;
    logic [31:0]   a_reg, a_next, b_reg, b_next, c_reg, c_next, pv_reg, pv_next;
    logic [1:0]    mstep_reg, mstep_next;
    logic [31:0]   ov_reg, ov_next;
    logic          ovld_reg, ovld_next, oacc_reg, oacc_next, olast_reg, olast_next;
    logic [CW-1:0] ocnt_reg, ocnt_next;

    logic          v_we, r_we;
    logic [IW-1:0] v_addr, r_addr;
    logic [31:0]   v_wdata, v_rdata;
    qsm3_pkg::range_t r_wdata, r_rdata;

    qsm3_ram #(.Width(32), .Depth(qsm3_pkg::MaxItems)) u_values (
        .aclk(aclk), .we(v_we), .addr(v_addr), .wdata(v_wdata), .rdata(v_rdata));
    qsm3_ram #(.Width(2*IW), .Depth(qsm3_pkg::MaxItems)) u_stack (
        .aclk(aclk), .we(r_we), .addr(r_addr), .wdata(r_wdata), .rdata(r_rdata));

    logic [CW-1:0] cap_eff;
    assign cap_eff = (cap_reg > 7'(qsm3_pkg::MaxItems)) ? CW'(qsm3_pkg::MaxItems)
                                                       : CW'(cap_reg);

    assign s_tready = (state_reg == ST_IDLE);
    assign pready   = 1'b1;
    assign prdata   = {25'd0, cap_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= 7'd64;
        end else if (psel && penable && pwrite && paddr == 3'd0) begin
            cap_reg <= pwdata[6:0];
        end
    end

    logic [IW:0] midsum;
    assign midsum = {1'b0, lo_reg} + {1'b0, hi_reg};

    always_comb begin
        state_next = state_reg;  fill_next = fill_reg;
        lo_next = lo_reg; hi_next = hi_reg; mid_next = mid_reg;
        up_next = up_reg; dn_next = dn_reg; ei_next = ei_reg; sp_next = sp_reg;
        a_next = a_reg; b_next = b_reg; c_next = c_reg; pv_next = pv_reg;
        mstep_next = mstep_reg;
        ov_next = ov_reg; ovld_next = ovld_reg; oacc_next = oacc_reg;
        olast_next = olast_reg; ocnt_next = ocnt_reg;
        v_we = 1'b0; v_addr = '0; v_wdata = '0;
        r_we = 1'b0; r_addr = sp_reg[IW-1:0]; r_wdata = '{lo: lo_reg, hi: hi_reg};

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    ov_next = '0; ovld_next = 1'b0; oacc_next = 1'b0; olast_next = 1'b1;
                    state_next = ST_OUT;
                    case (s_tdata[1:0])
                        qsm3_pkg::ACT_ADD: begin
                            if (fill_reg < cap_eff) begin
                                v_we = 1'b1; v_addr = fill_reg[IW-1:0];
                                v_wdata = s_tdata[33:2];
                                fill_next = fill_reg + 1'b1;
                                oacc_next = 1'b1;
                                ocnt_next = fill_reg + 1'b1;
                            end else begin
                                ocnt_next = fill_reg;
                            end
                        end
                        qsm3_pkg::ACT_SORT: begin
                            ocnt_next = fill_reg;
                            if (fill_reg == '0) begin
                                state_next = ST_OUT;
                            end else if (fill_reg == CW'(1)) begin
                                ei_next = '0; state_next = ST_EMITR;
                            end else begin
                                lo_next = '0; hi_next = IW'(fill_reg - 1'b1);
                                sp_next = '0; state_next = ST_M0;
                            end
                        end
                        qsm3_pkg::ACT_CLEAR: begin
                            fill_next = '0; ocnt_next = '0;
                        end
                        default: ocnt_next = fill_reg;
                    endcase
                end
            end
            ST_OUT: if (m_tready) state_next = ST_IDLE;
            // median of three: load lo, mid, hi
            ST_M0: begin
                mid_next = midsum[IW:1];
                v_addr = lo_reg; state_next = ST_M1;
            end
            ST_M1: begin
                a_next = v_rdata; v_addr = mid_reg; state_next = ST_M2;
            end
            ST_M2: begin
                b_next = v_rdata; v_addr = hi_reg; state_next = ST_M2W;
            end
            ST_M2W: begin
                c_next = v_rdata; state_next = ST_M3;
            end
            ST_M3: begin
                // three compare-swaps on a, b, c, written back afterwards
                if (qsm3_pkg::lt32(b_reg, a_reg)) begin
                    a_next = b_reg; b_next = a_reg;
                end
                state_next = ST_M3W;
            end
            ST_M3W: begin
                if (qsm3_pkg::lt32(c_reg, b_reg)) begin
                    b_next = c_reg; c_next = b_reg;
                end
                mstep_next = 2'd0;
                state_next = ST_MSW;
            end
            ST_MSW: begin
                unique case (mstep_reg)
                    2'd0: begin
                        if (qsm3_pkg::lt32(b_reg, a_reg)) begin
                            a_next = b_reg; b_next = a_reg;
                        end
                        mstep_next = 2'd1;
                    end
                    2'd1: begin
                        v_we = 1'b1; v_addr = hi_reg; v_wdata = c_reg; mstep_next = 2'd2;
                    end
                    2'd2: begin
                        // smallest of the three goes to mid; the pivot (median) goes to lo next
                        v_we = 1'b1; v_addr = mid_reg; v_wdata = a_reg; mstep_next = 2'd3;
                    end
                    default: begin
                        // mid on lo: only two distinct entries, the smaller one is the pivot
                        v_we = 1'b1; v_addr = lo_reg;
                        v_wdata = (mid_reg == lo_reg) ? a_reg : b_reg;
                        pv_next = (mid_reg == lo_reg) ? a_reg : b_reg;
                        up_next = lo_reg + 1'b1; dn_next = hi_reg;
                        state_next = ST_UPR;
                    end
                endcase
            end
            ST_UPR: begin
                v_addr = up_reg; state_next = ST_UPC;
            end
            ST_UPC: begin
                if (!qsm3_pkg::lt32(pv_reg, v_rdata) && up_reg < hi_reg) begin
                    up_next = up_reg + 1'b1; v_addr = up_reg + 1'b1;
                end else begin
                    a_next = v_rdata; v_addr = dn_reg; state_next = ST_DNC;
                end
            end
            ST_DNC: begin
                if (qsm3_pkg::lt32(pv_reg, v_rdata) && dn_reg > lo_reg) begin
                    dn_next = dn_reg - 1'b1; v_addr = dn_reg - 1'b1;
                end else begin
                    b_next = v_rdata;
                    state_next = (up_reg < dn_reg) ? ST_SWW : ST_FIN;
                end
            end
            ST_SWW: begin
                v_we = 1'b1; v_addr = up_reg; v_wdata = b_reg; state_next = ST_SWW2;
            end
            ST_SWW2: begin
                v_we = 1'b1; v_addr = dn_reg; v_wdata = a_reg; state_next = ST_UPR;
            end
            ST_FIN: begin
                v_we = 1'b1; v_addr = lo_reg; v_wdata = b_reg; state_next = ST_FIN2;
            end
            ST_FIN2: begin
                v_we = 1'b1; v_addr = dn_reg; v_wdata = pv_reg; state_next = ST_PUSH1;
            end
            ST_PUSH1: begin
                if ({1'b0, dn_reg} + 1'b1 < {1'b0, hi_reg}) begin
                    r_we = 1'b1; r_addr = sp_reg[IW-1:0];
                    r_wdata = '{lo: dn_reg + 1'b1, hi: hi_reg};
                    sp_next = sp_reg + 1'b1;
                end
                state_next = ST_PUSH2;
            end
            ST_PUSH2: begin
                if ({1'b0, dn_reg} > {1'b0, lo_reg} + 1'b1) begin
                    r_we = 1'b1; r_addr = sp_reg[IW-1:0];
                    r_wdata = '{lo: lo_reg, hi: dn_reg - 1'b1};
                    sp_next = sp_reg + 1'b1;
                end
                state_next = ST_POP;
            end
            ST_POP: begin
                if (sp_reg == '0) begin
                    ei_next = '0; v_addr = '0; state_next = ST_EMITR;
                end else begin
                    sp_next = sp_reg - 1'b1; r_addr = IW'(sp_reg - 1'b1);
                    state_next = ST_POPW;
                end
            end
            ST_POPW: begin
                lo_next = r_rdata.lo; hi_next = r_rdata.hi;
                state_next = (r_rdata.hi > r_rdata.lo) ? ST_M0 : ST_POP;
            end
            ST_EMITR: begin
                v_addr = ei_reg; state_next = ST_PSW0;
            end
            ST_PSW0: begin
                ov_next = v_rdata; ovld_next = 1'b1; oacc_next = 1'b0;
                ocnt_next = fill_reg;
                olast_next = ({1'b0, ei_reg} + 1'b1 == fill_reg);
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (m_tready) begin
                    if (olast_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        ei_next = ei_reg + 1'b1; state_next = ST_EMITR;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            sp_reg    <= '0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            sp_reg    <= sp_next;
        end
        lo_reg <= lo_next; hi_reg <= hi_next; mid_reg <= mid_next;
        up_reg <= up_next; dn_reg <= dn_next; ei_reg <= ei_next;
        a_reg <= a_next; b_reg <= b_next; c_reg <= c_next; pv_reg <= pv_next;
        mstep_reg <= mstep_next;
        ov_reg <= ov_next; ovld_reg <= ovld_next; oacc_reg <= oacc_next;
        olast_reg <= olast_next; ocnt_reg <= ocnt_next;
    end

    assign m_tvalid = (state_reg == ST_OUT) || (state_reg == ST_EMIT);
    assign m_tlast  = olast_reg;
    assign m_tdata  = {7'd0, ocnt_reg, oacc_reg, ovld_reg, ov_reg};

    ap_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("request taken while result pending");
    ap_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CW'(qsm3_pkg::MaxItems)) else $error("fill count overflow");
    ap_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata)) else $error("result changed");
endmodule
`default_nettype wire

@@ sim/tb_quicksort_median_of_three_core.sv @@
// Testbench for the median-of-three quicksort core: stream requests, predicted results.
module tb_quicksort_median_of_three_core;

    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam logic [2:0] REG_CAPACITY = 3'd0;
    localparam int STALL_LIMIT = 100000;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic [31:0] value;
        logic        valid;
        logic        accepted;
        logic [6:0]  count;
        logic        last;
    } sorted_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // action[1:0], item_value[33:2], zero pad
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;        // out_value[31:0], out_valid[32], accepted[33],
                                 // stored_count[40:34], zero pad
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    quicksort_median_of_three_core i_dut (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready,
        .m_tdata, .m_tlast, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    always #5 aclk = ~aclk;

    // predictor state
    logic [31:0]    store_model [qsm3_pkg::MaxItems];
    int             fill_model = 0;
    int             capacity_model = 64;
    sorted_result_t sorted_q [$];

    int errors = 0;
    int requests_sent = 0;
    int results_seen = 0;
    int sorts_sent = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_req = 1'b0;
    bit hold_active = 1'b0;
    int quiet_cycles = 0;

    function automatic sorted_result_t mk(logic [31:0] v, logic vl, logic acc, int cnt,
                                          logic lst);
        sorted_result_t r;
        r.value = v; r.valid = vl; r.accepted = acc; r.count = 7'(cnt); r.last = lst;
        return r;
    endfunction

    function automatic void predict_request(logic [1:0] act, logic [31:0] val);
        int cap;
        logic [31:0] t;
        int j;
        cap = (capacity_model > qsm3_pkg::MaxItems) ? qsm3_pkg::MaxItems : capacity_model;
        case (act)
            qsm3_pkg::ACT_ADD: begin
                if (fill_model < cap) begin
                    store_model[fill_model] = val;
                    fill_model++;
                    sorted_q.push_back(mk('0, 1'b0, 1'b1, fill_model, 1'b1));
                end else
                    sorted_q.push_back(mk('0, 1'b0, 1'b0, fill_model, 1'b1));
            end
            qsm3_pkg::ACT_SORT: begin
                if (fill_model == 0)
                    sorted_q.push_back(mk('0, 1'b0, 1'b0, 0, 1'b1));
                else begin
                    // result order is fixed by the values alone, any stable sort will do
                    for (int i = 1; i < fill_model; i++) begin
                        t = store_model[i];
                        j = i - 1;
                        while (j >= 0 && $signed(t) < $signed(store_model[j])) begin
                            store_model[j + 1] = store_model[j];
                            j--;
                        end
                        store_model[j + 1] = t;
                    end
                    for (int i = 0; i < fill_model; i++)
                        sorted_q.push_back(mk(store_model[i], 1'b1, 1'b0, fill_model,
                                              i == fill_model - 1));
                end
            end
            qsm3_pkg::ACT_CLEAR: begin
                fill_model = 0;
                sorted_q.push_back(mk('0, 1'b0, 1'b0, 0, 1'b1));
            end
            default: sorted_q.push_back(mk('0, 1'b0, 1'b0, fill_model, 1'b1));
        endcase
    endfunction

    task automatic send_request(logic [1:0] act, logic [31:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'b0, val, act};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_request(act, val);
        requests_sent++;
        if (act == qsm3_pkg::ACT_SORT) sorts_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sorted_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_capacity(int cap);
        wait_drained();
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= REG_CAPACITY; pwdata <= 32'(cap);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        capacity_model = cap & 'h7f;
        @(posedge aclk);
    endtask

    // result checker
    always @(posedge aclk) begin
        sorted_result_t e;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (sorted_q.size() == 0) begin
                    $display("%0t: unexpected result %h last %b", $time, m_tdata, m_tlast);
                    errors++;
                end else begin
                    e = sorted_q.pop_front();
                    if (m_tdata[31:0] !== e.value || m_tdata[32] !== e.valid ||
                        m_tdata[33] !== e.accepted || m_tdata[40:34] !== e.count ||
                        m_tlast !== e.last) begin
                        $display("%0t: mismatch expected val %h vld %b acc %b cnt %0d last %b",
                                 $time, e.value, e.valid, e.accepted, e.count, e.last);
                        $display("%0t:          actual   val %h vld %b acc %b cnt %0d last %b",
                                 $time, m_tdata[31:0], m_tdata[32], m_tdata[33],
                                 m_tdata[40:34], m_tlast);
                        errors++;
                    end
                end
            end
        end
    end

    // receiver backpressure
    always @(posedge aclk) begin
        if (aresetn) begin
            if (hold_active)
                m_tready <= 1'b0;
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // one long receiver hold, counted here once requested
    initial begin
        wait (hold_req);
        @(posedge aclk);
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_active = 1'b0;
    end

    // watchdog on handshake progress
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no progress, %0d results still due", $time, sorted_q.size());
                $display("tb_quicksort_median_of_three_core: done, errors");
                $finish;
            end
        end
    end

    function automatic logic [31:0] rand_value();
        case ($urandom_range(3))
            0: return $urandom_range(15) - 8;   // many duplicates
            1: return {$urandom_range(1) ? 32'h8000_0000 : 32'h7fff_fff0} + $urandom_range(15);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        send_request(qsm3_pkg::ACT_SORT, '0);                 // empty sort
        send_request(qsm3_pkg::ACT_ADD, 32'h7fff_ffff);
        send_request(qsm3_pkg::ACT_ADD, 32'h8000_0000);
        send_request(qsm3_pkg::ACT_ADD, 32'h0000_0000);
        send_request(qsm3_pkg::ACT_ADD, 32'hffff_ffff);
        send_request(qsm3_pkg::ACT_ADD, 32'h0000_0001);
        send_request(qsm3_pkg::ACT_ADD, 32'hffff_ffff);
        send_request(qsm3_pkg::ACT_SORT, '0);
        send_request(ACT_NONE, 32'hffff_ffff);                // unused action
        send_request(qsm3_pkg::ACT_ADD, 32'h8000_0001);       // appended after sorted values
        send_request(qsm3_pkg::ACT_SORT, '0);
        send_request(qsm3_pkg::ACT_CLEAR, 32'h5a5a_5a5a);
        send_request(qsm3_pkg::ACT_SORT, '0);
        send_request(qsm3_pkg::ACT_ADD, 32'h1234_5678);
        send_request(qsm3_pkg::ACT_SORT, '0);                 // single value
        send_request(qsm3_pkg::ACT_CLEAR, '0);
    endtask

    task automatic test_capacity();
        write_capacity(0);
        send_request(qsm3_pkg::ACT_ADD, 32'd4);               // refused, zero capacity
        write_capacity(1);
        send_request(qsm3_pkg::ACT_ADD, 32'd5);
        send_request(qsm3_pkg::ACT_ADD, 32'd6);               // refused, store full
        send_request(qsm3_pkg::ACT_CLEAR, '0);
        write_capacity(3);
        for (int i = 0; i < 5; i++) send_request(qsm3_pkg::ACT_ADD, rand_value());
        write_capacity(2);                                    // below fill count
        send_request(qsm3_pkg::ACT_ADD, 32'd7);
        send_request(qsm3_pkg::ACT_SORT, '0);
        send_request(qsm3_pkg::ACT_CLEAR, '0);
        write_capacity(127);                                  // above the store size
        for (int i = 0; i < 66; i++) send_request(qsm3_pkg::ACT_ADD, rand_value());
        send_request(qsm3_pkg::ACT_SORT, '0);                 // full store, random mix
        send_request(qsm3_pkg::ACT_CLEAR, '0);
        write_capacity(64);
        for (int i = 0; i < 64; i++) send_request(qsm3_pkg::ACT_ADD, 32'(64 - i));
        send_request(qsm3_pkg::ACT_SORT, '0);
        send_request(qsm3_pkg::ACT_CLEAR, '0);
    endtask

    task automatic test_random(int n);
        int target;
        target = requests_sent + n;
        while (requests_sent < target) begin
            if ($urandom_range(9) == 0)
                send_request(2'($urandom_range(3)), $urandom);    // noise
            else begin
                repeat ($urandom_range(12)) send_request(qsm3_pkg::ACT_ADD, rand_value());
                send_request(qsm3_pkg::ACT_SORT, $urandom);
                if ($urandom_range(2) == 0) send_request(qsm3_pkg::ACT_CLEAR, $urandom);
            end
        end
    endtask

    task automatic test_backpressure();
        wait_drained();
        send_request(qsm3_pkg::ACT_CLEAR, '0);
        hold_req = 1'b1;
        for (int i = 0; i < 20; i++) send_request(qsm3_pkg::ACT_ADD, rand_value());
        send_request(qsm3_pkg::ACT_SORT, '0);
        send_request(ACT_NONE, '0);
    endtask

    initial begin
        int limit;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_capacity();
        write_capacity(40);
        send_idle_pct = 12; recv_idle_pct = 82;
        test_random(100);
        write_capacity(3);
        send_idle_pct = 82; recv_idle_pct = 12;
        test_random(70);
        write_capacity(64);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random(90);
        test_backpressure();
        s_tvalid <= 1'b0;
        limit = 0;
        while (sorted_q.size() != 0 && limit < STALL_LIMIT) begin
            @(posedge aclk);
            limit++;
        end
        repeat (50) @(posedge aclk);
        $display("covered %0d requests (%0d sorts), %0d results checked,",
                 requests_sent, sorts_sent, results_seen);
        $display("capacity 0 to 127, full store, idle and long receiver stall phases");
        if (errors == 0 && sorted_q.size() == 0)
            $display("tb_quicksort_median_of_three_core: done, clean");
        else
            $display("tb_quicksort_median_of_three_core: done, errors");
        $finish;
    end
endmodule
